/* hw/rtl/lud_pkg.sv */
// ----------------------------------------------------------------------------
// lud_pkg
// Shared widths, byte classification constants and the result group type
// of the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lud_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int MAX_RES  = 4;
    localparam int HELD_MAX = 3;

    // byte classes
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] PAY_C_MASK = 8'h3F;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // results caused by one input byte
    typedef struct packed {
        logic [2:0]                  count;
        logic                        eot;
        logic [MAX_RES-1:0][CP_W-1:0] cp;
    } lud_group_t;

endpackage : lud_pkg

`default_nettype wire

/* hw/rtl/lud_decode.sv */
// ----------------------------------------------------------------------------
// lud_decode
// Sequence state and single-pass decode of one byte into a group of up to
// four code points.
// ----------------------------------------------------------------------------
`default_nettype none

module lud_decode
    import lud_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv_i,
    input  wire logic [BYTE_W-1:0] byte_i,
    input  wire logic              eot_i,
    output lud_group_t             group_o
);

    logic [HELD_MAX-1:0][BYTE_W-1:0] held_reg, held_next;
    logic [1:0]                      count_reg, count_next;
    logic [2:0]                      len_reg, len_next;
    logic [CP_W-1:0]                 part_reg, part_next;

    logic            seq_open;
    logic            is_cont;
    logic [2:0]      fresh_len;
    logic [CP_W-1:0] fresh_pay;
    logic            fresh_raw;
    logic [CP_W-1:0] acc_val;
    logic [2:0]      new_cnt;
    logic [2:0]      base;
    logic [CP_W-1:0] byte_cp;

    // classify and decode the byte against the open sequence
    always_comb begin
        held_next     = held_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        part_next     = part_reg;
        group_o.count = 3'd0;
        group_o.eot   = eot_i;
        group_o.cp    = '0;

        seq_open = (len_reg != SEQ_NONE);
        is_cont  = ((byte_i & CONT_MASK) == CONT_TAG);
        byte_cp  = {{(CP_W-BYTE_W){1'b0}}, byte_i};
        acc_val  = {part_reg[CP_W-7:0], byte_i[5:0]};
        new_cnt  = {1'b0, count_reg} + 3'd1;
        base     = seq_open ? {1'b0, count_reg} : 3'd0;

        if ((byte_i & LEAD2_MASK) == LEAD2_TAG) begin
            fresh_len = SEQ_LEN2;
            fresh_pay = {{(CP_W-BYTE_W){1'b0}}, byte_i & PAY2_MASK};
        end else if ((byte_i & LEAD3_MASK) == LEAD3_TAG) begin
            fresh_len = SEQ_LEN3;
            fresh_pay = {{(CP_W-BYTE_W){1'b0}}, byte_i & PAY3_MASK};
        end else if ((byte_i & LEAD4_MASK) == LEAD4_TAG) begin
            fresh_len = SEQ_LEN4;
            fresh_pay = {{(CP_W-BYTE_W){1'b0}}, byte_i & PAY4_MASK};
        end else begin
            fresh_len = SEQ_NONE;
            fresh_pay = '0;
        end
        fresh_raw = (fresh_len == SEQ_NONE) || eot_i;

        if (seq_open && is_cont) begin
            if (new_cnt >= len_reg) begin
                // sequence complete
                group_o.count = 3'd1;
                group_o.cp[0] = acc_val;
                count_next    = 2'd0;
                len_next      = SEQ_NONE;
            end else begin
                held_next[count_reg] = byte_i;
                count_next           = new_cnt[1:0];
                part_next            = acc_val;
                if (eot_i) begin
                    // text ended mid-sequence: flush everything raw
                    for (int k = 0; k < HELD_MAX; k++) begin
                        group_o.cp[k] = {{(CP_W-BYTE_W){1'b0}}, held_next[k]};
                    end
                    group_o.count = new_cnt;
                    count_next    = 2'd0;
                    len_next      = SEQ_NONE;
                end
            end
        end else begin
            // flush any broken sequence, then decode the byte from scratch
            for (int k = 0; k < HELD_MAX; k++) begin
                group_o.cp[k] = (3'(k) < base) ?
                                {{(CP_W-BYTE_W){1'b0}}, held_reg[k]} : byte_cp;
            end
            group_o.cp[MAX_RES-1] = byte_cp;
            if (fresh_raw) begin
                group_o.count = base + 3'd1;
                count_next    = 2'd0;
                len_next      = SEQ_NONE;
            end else begin
                group_o.count = base;
                held_next[0]  = byte_i;
                count_next    = 2'd1;
                len_next      = fresh_len;
                part_next     = fresh_pay;
            end
        end
    end

    // advance the sequence state on each decoded byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            len_reg   <= SEQ_NONE;
        end else if (adv_i) begin
            count_reg <= count_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_i) begin
            held_reg <= held_next;
            part_reg <= part_next;
        end
    end

    // the text always leaves the decoder empty
    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_i && eot_i |=> (len_reg == SEQ_NONE) && (count_reg == 2'd0))
        else $error("sequence left open after end of text");

    // an open sequence holds at least its lead and fewer bytes than its length
    a_held_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg != SEQ_NONE) |-> (count_reg != 2'd0) && ({1'b0, count_reg} < len_reg))
        else $error("held byte count out of range for open sequence");

endmodule : lud_decode

`default_nettype wire

/* hw/rtl/lud_out_buffer.sv */
// ----------------------------------------------------------------------------
// lud_out_buffer
// Result group register; hands out its code points one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lud_out_buffer
    import lud_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load_i,
    input  wire lud_group_t   group_i,
    output logic              free_o,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,   // [20:0] code_point, [23:21] zero
    output logic              m_tlast,   // last_of_run
    output logic [0:0]        m_tuser    // [0] text_finished
);

    logic                         valid_reg;
    logic [1:0]                   idx_reg;
    logic [2:0]                   n_reg;
    logic                         eot_reg;
    logic [MAX_RES-1:0][CP_W-1:0] cp_reg;

    logic last_slot;
    logic fire;

    // flag the final slot of the group
    always_comb begin
        last_slot = ({1'b0, idx_reg} == (n_reg - 3'd1));
        fire      = valid_reg && m_tready;
        free_o    = !valid_reg || (fire && last_slot);
        m_tvalid  = valid_reg;
        m_tdata   = {{(24-CP_W){1'b0}}, cp_reg[idx_reg]};
        m_tlast   = last_slot;
        m_tuser   = eot_reg && last_slot;
    end

    // load a new group or advance through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load_i) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (fire) begin
            if (last_slot) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            n_reg   <= group_i.count;
            eot_reg <= group_i.eot;
            cp_reg  <= group_i.cp;
        end
    end

    // never overwrite a group that still has items to deliver
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> free_o)
        else $error("group loaded while previous one pending");

    // the slot pointer stays inside a non-empty group
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (n_reg != 3'd0) && ({1'b0, idx_reg} < n_reg))
        else $error("slot index outside result group");

endmodule : lud_out_buffer

`default_nettype wire

/* hw/rtl/lenient_utf8_decoder_unit.sv */
// ----------------------------------------------------------------------------
// lenient_utf8_decoder_unit
// Lenient streaming UTF-8 decoder: one text byte per item in, code points out.
// ----------------------------------------------------------------------------
// An accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while m_tready is high and each byte yields
// at most one result; a byte that yields k results (k up to four) holds the
// result register until the one-item-per-cycle output port has sent all k.
// Reset: synchronous active-low aresetn empties the input register, the
// result register and any open sequence.
`default_nettype none

module lenient_utf8_decoder_unit
    import lud_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_tlast,   // last_of_run
    output logic [0:0]       m_tuser    // [0] text_finished
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eot_reg;

    logic       buf_free;
    logic       adv;
    lud_group_t group;

    // take a new item whenever the input register is empty or drains this cycle
    assign adv      = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    lud_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv_i   (adv),
        .byte_i  (in_byte_reg),
        .eot_i   (in_eot_reg),
        .group_o (group)
    );

    lud_out_buffer u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (adv && (group.count != 3'd0)),
        .group_i  (group),
        .free_o   (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule : lenient_utf8_decoder_unit

`default_nettype wire

/* sim/lenient_utf8_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lenient_utf8_decoder_unit_tb
// Streams UTF-8 text bytes into the decoder and checks every code point item
// against a cycle-free decoder written here. Directed texts cover plain and
// raw bytes, complete sequences, broken sequences and texts that end inside
// a sequence. Random texts follow under changing idle patterns, a long output
// stall and pauses that let the decoder drain.
// ----------------------------------------------------------------------------

module lenient_utf8_decoder_unit_tb;
    import lud_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 10;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_of_run;
        logic            text_finished;
    } cp_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    // decoded code points still to come, oldest first
    cp_result_t      cp_expected [$];

    // decoder state mirrored in the testbench
    logic [7:0]      held_copy [HELD_MAX];
    logic [1:0]      held_num;
    logic [2:0]      open_len;
    logic [CP_W-1:0] partial_cp;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;
    bit stall_go      = 1'b0;
    int bytes_sent    = 0;
    int cycle_count   = 0;
    int error_count   = 0;

    lenient_utf8_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------
    function automatic void clear_sequence();
        for (int k = 0; k < HELD_MAX; k++) held_copy[k] = '0;
        held_num   = '0;
        open_len   = SEQ_NONE;
        partial_cp = '0;
    endfunction

    function automatic void expect_cp(input logic [CP_W-1:0] cp);
        cp_result_t item;
        item.code_point    = cp;
        item.last_of_run   = 1'b0;
        item.text_finished = 1'b0;
        cp_expected.insert(cp_expected.size(), item);
    endfunction

    // emit the lead and the held continuations raw, then drop the sequence
    function automatic void flush_held();
        for (int k = 0; k < held_num; k++) expect_cp(CP_W'(held_copy[k]));
        clear_sequence();
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        int              first;
        logic            fresh;
        logic [2:0]      taken;
        logic [2:0]      lead_len;
        logic [CP_W-1:0] lead_pay;
        first = cp_expected.size();
        fresh = 1'b1;
        // continue or break an open sequence
        if (open_len != SEQ_NONE) begin
            if ((b & CONT_MASK) == CONT_TAG) begin
                fresh      = 1'b0;
                taken      = {1'b0, held_num} + 3'd1;
                partial_cp = (partial_cp << 6) | CP_W'(b & PAY_C_MASK);
                if (taken >= open_len) begin
                    expect_cp(partial_cp);
                    clear_sequence();
                end else begin
                    held_copy[held_num] = b;
                    held_num = taken[1:0];
                    if (eot) flush_held();
                end
            end else begin
                flush_held();
            end
        end
        // decode the byte from scratch
        if (fresh) begin
            lead_len = SEQ_NONE;
            lead_pay = '0;
            if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                lead_len = SEQ_LEN2;
                lead_pay = CP_W'(b & PAY2_MASK);
            end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                lead_len = SEQ_LEN3;
                lead_pay = CP_W'(b & PAY3_MASK);
            end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                lead_len = SEQ_LEN4;
                lead_pay = CP_W'(b & PAY4_MASK);
            end
            if (lead_len == SEQ_NONE || eot) begin
                expect_cp(CP_W'(b));
            end else begin
                held_copy[0] = b;
                held_num     = 2'd1;
                open_len     = lead_len;
                partial_cp   = lead_pay;
            end
        end
        // mark the last item of this byte's run
        if (cp_expected.size() > first) begin
            cp_expected[cp_expected.size()-1].last_of_run   = 1'b1;
            cp_expected[cp_expected.size()-1].text_finished = eot;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, eot);
        bytes_sent++;
    endtask

    // drop valid and hold until every predicted code point has arrived
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (cp_expected.size() != 0);
    endtask

    // one random character: mostly well formed, some truncated or stray
    task automatic send_random_char();
        logic [7:0] seq [4];
        logic [7:0] rnd;
        int         n;
        int         len;
        rnd = 8'($urandom);
        for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom)};
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                seq[0] = {1'b0, rnd[6:0]};
                n = 1;
            end
            3, 4: begin
                seq[0] = {3'b110, rnd[4:0]};
                n = 2;
            end
            5: begin
                seq[0] = {4'b1110, rnd[3:0]};
                n = 3;
            end
            6: begin
                seq[0] = {5'b11110, rnd[2:0]};
                n = 4;
            end
            7: begin
                len = $urandom_range(2, 4);
                seq[0] = (len == 2) ? {3'b110, rnd[4:0]} :
                         (len == 3) ? {4'b1110, rnd[3:0]} : {5'b11110, rnd[2:0]};
                n = $urandom_range(1, len - 1);
            end
            8: begin
                seq[0] = rnd;
                n = 1;
            end
            default: begin
                seq[0] = {2'b10, rnd[5:0]};
                n = 1;
            end
        endcase
        for (int i = 0; i < n; i++) send_byte(seq[i], $urandom_range(0, 19) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_passthrough_bytes();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_complete_sequences();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_broken_sequences();
        // lead interrupted by a new lead, which opens its own sequence
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        // three held bytes flushed by a plain byte
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_early_end();
        // lead as the final byte of a text
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b1);
    endtask

    task automatic test_random_text(input int sidle, input int ridle, input int nbytes);
        int start;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) send_random_char();
    endtask

    // hold the output off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        int start;
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_go = 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < 10) send_random_char();
        wait_for_results();
    endtask

    // let the decoder drain completely between short bursts
    task automatic test_drain_pause();
        int start;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (3) begin
            start = bytes_sent;
            while (bytes_sent - start < 6) send_random_char();
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    // pace the receiver, with a long hold-off on request
    always @(posedge aclk) begin
        if (stall_go) begin
            stall_left = STALL_CYCLES;
            stall_go   = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each accepted item with the oldest prediction
    always @(posedge aclk) begin
        cp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (cp_expected.size() == 0) begin
                $error("unexpected code point item %h", m_tdata[CP_W-1:0]);
                error_count++;
            end else begin
                want = cp_expected.pop_front();
                if (m_tdata[CP_W-1:0] !== want.code_point) begin
                    $error("code_point: expected %h, got %h",
                           want.code_point, m_tdata[CP_W-1:0]);
                    error_count++;
                end
                if (m_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b", want.last_of_run, m_tlast);
                    error_count++;
                end
                if (m_tuser[0] !== want.text_finished) begin
                    $error("text_finished: expected %b, got %b",
                           want.text_finished, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("lenient_utf8_decoder_unit_tb: errors");
        $finish;
    end

    initial begin
        clear_sequence();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_passthrough_bytes();
        test_complete_sequences();
        test_broken_sequences();
        test_early_end();
        test_random_text(34, 78, 18);
        test_random_text(78, 34, 18);
        test_random_text(0, 0, 18);
        test_output_backpressure();
        test_drain_pause();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("lenient_utf8_decoder_unit_tb: clean");
        end else begin
            $display("lenient_utf8_decoder_unit_tb: errors");
        end
        $finish;
    end

endmodule
